/* src/pdq_pkg.sv */
`default_nettype none
package pdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_COUNT  = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] cref;
    logic [7:0]  code;
    logic        urgent;
  } entry_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] ticket_key;
    logic [15:0] customer_ref;
    logic [7:0]  issue_code;
    logic        urgent;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_key;
    logic [15:0] found_ref;
    logic [7:0]  found_code;
    logic        found_urgent;
    logic [4:0]  type_count;
  } out_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_TAKE_PREV = 2'd1,
    OP_TAKE_NEXT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load;
  } cell_ctl_t;

  typedef struct packed {
    logic active;
    logic last;
  } scan_stat_t;

endpackage
`default_nettype wire

/* src/pdq_cell.sv */
`default_nettype none
module pdq_cell (
  input  wire logic              clk,
  input  wire pdq_pkg::cell_ctl_t ctl,
  input  wire pdq_pkg::entry_t   new_entry,
  input  wire pdq_pkg::entry_t   prev_entry,
  input  wire pdq_pkg::entry_t   next_entry,
  output pdq_pkg::entry_t        entry
);

  pdq_pkg::entry_t entry_r;
  pdq_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = new_entry;
    end else begin
      case (ctl.op)
        pdq_pkg::OP_TAKE_PREV: entry_nxt = prev_entry;
        pdq_pkg::OP_TAKE_NEXT: entry_nxt = next_entry;
        default:               entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

/* src/pdq_scan.sv */
`default_nettype none
module pdq_scan #(
  parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire pdq_pkg::in_t               query,
  input  wire pdq_pkg::entry_t            head,
  input  wire logic [$clog2(DEPTH+1)-1:0] occ,
  output pdq_pkg::scan_stat_t             stat,
  output pdq_pkg::out_t                   res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH+1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            hit_r, hit_nxt;
  pdq_pkg::entry_t hit_ent_r, hit_ent_nxt;
  logic            srch_r, srch_nxt;
  logic [15:0]     key_r, key_nxt;
  logic [7:0]      code_r, code_nxt;

  logic in_range;
  logic code_hit;
  logic key_hit;
  logic last;

  assign in_range = (OCC_W'(pos_r) < occ);
  assign code_hit = in_range && (head.code == code_r);
  // first match from the front wins
  assign key_hit  = in_range && srch_r && !hit_r && (head.key == key_r);
  assign last     = (state_r == S_SCAN) && (pos_r == IDX_W'(DEPTH-1));

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    hit_nxt     = hit_r;
    hit_ent_nxt = hit_ent_r;
    srch_nxt    = srch_r;
    key_nxt     = key_r;
    code_nxt    = code_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_SCAN;
          pos_nxt   = '0;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          srch_nxt  = (query.command == pdq_pkg::CMD_SEARCH);
          key_nxt   = query.ticket_key;
          code_nxt  = query.issue_code;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 5'(code_hit);
        if (key_hit) begin
          hit_nxt     = 1'b1;
          hit_ent_nxt = head;
        end
        pos_nxt = pos_r + IDX_W'(1);
        if (last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    hit_r     <= hit_nxt;
    hit_ent_r <= hit_ent_nxt;
    srch_r    <= srch_nxt;
    key_r     <= key_nxt;
    code_r    <= code_nxt;
  end

  always_comb begin
    pdq_pkg::entry_t ent;
    ent = key_hit ? head : hit_ent_r;
    res = '0;
    if (srch_r) begin
      if (occ == '0) begin
        res.status = pdq_pkg::ST_EMPTY;
      end else if (hit_r || key_hit) begin
        res.status       = pdq_pkg::ST_OK;
        res.found_key    = ent.key;
        res.found_ref    = ent.cref;
        res.found_code   = ent.code;
        res.found_urgent = ent.urgent;
      end else begin
        res.status = pdq_pkg::ST_NOT_FOUND;
      end
    end else begin
      res.status     = pdq_pkg::ST_OK;
      res.type_count = cnt_nxt;
    end
  end

  assign stat.active = (state_r == S_SCAN);
  assign stat.last   = last;

endmodule
`default_nettype wire

/* src/priority_deque_ticket_store_core.sv */
// Ticket deque held in a row of DEPTH register cells, cell 0 being the front.
// Insert, remove, peek and unknown commands need no scan: the result strobe
// rises in the cycle after the request is taken and busy stays low, so these
// may be issued every cycle. Count and search rotate the whole row once through
// the front cell, which is compared in each cycle; busy is high meanwhile,
// and the row comes back in its original order. Each accepted request gives
// exactly one result, shown for one cycle on out_strobe; the receiver must
// take it then, as there is no way to hold it.
`default_nettype none
module priority_deque_ticket_store_core #(
  parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire pdq_pkg::in_t in_req,
  output logic              out_strobe,
  output pdq_pkg::out_t     out_res
);

  localparam int OCC_W = $clog2(DEPTH+1);

  pdq_pkg::entry_t    cell_q [DEPTH];
  pdq_pkg::cell_ctl_t cell_ctl [DEPTH];
  pdq_pkg::entry_t    new_entry;
  pdq_pkg::scan_stat_t scan_stat;
  pdq_pkg::out_t      scan_res;

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  pdq_pkg::out_t    out_res_r, out_res_nxt;

  logic accept;
  logic is_empty;
  logic is_full;
  logic do_push;
  logic do_pop;
  logic do_scan;

  assign accept   = start && !busy;
  assign is_empty = (occ_r == '0);
  assign is_full  = (occ_r == OCC_W'(DEPTH));
  assign do_push  = accept && (in_req.command == pdq_pkg::CMD_INSERT) && !is_full;
  assign do_pop   = accept && (in_req.command == pdq_pkg::CMD_REMOVE) && !is_empty;
  assign do_scan  = accept && ((in_req.command == pdq_pkg::CMD_COUNT) ||
                               (in_req.command == pdq_pkg::CMD_SEARCH));

  assign new_entry.key    = in_req.ticket_key;
  assign new_entry.cref   = in_req.customer_ref;
  assign new_entry.code   = in_req.issue_code;
  assign new_entry.urgent = in_req.urgent;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].op   = pdq_pkg::OP_HOLD;
      cell_ctl[i].load = 1'b0;
      if (do_push && in_req.urgent) begin
        cell_ctl[i].op = pdq_pkg::OP_TAKE_PREV;
      end else if (do_push) begin
        cell_ctl[i].load = (occ_r == OCC_W'(i));
      end else if (do_pop || scan_stat.active) begin
        // the last cell wraps to the front so a scan rotates the full row
        cell_ctl[i].op = pdq_pkg::OP_TAKE_NEXT;
      end
    end

    pdq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_entry  (new_entry),
      .prev_entry ((i == 0) ? new_entry : cell_q[(i + DEPTH - 1) % DEPTH]),
      .next_entry (cell_q[(i + 1) % DEPTH]),
      .entry      (cell_q[i])
    );
  end

  pdq_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (do_scan),
    .query (in_req),
    .head  (cell_q[0]),
    .occ   (occ_r),
    .stat  (scan_stat),
    .res   (scan_res)
  );

  assign busy = scan_stat.active;

  always_comb begin
    occ_nxt = occ_r;
    if (do_push) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (do_pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    if (scan_stat.last) begin
      out_strobe_nxt = 1'b1;
      out_res_nxt    = scan_res;
    end else if (accept && !do_scan) begin
      out_strobe_nxt     = 1'b1;
      out_res_nxt.status = pdq_pkg::ST_OK;
      case (in_req.command)
        pdq_pkg::CMD_INSERT: begin
          if (is_full) begin
            out_res_nxt.status = pdq_pkg::ST_FULL;
          end
        end
        pdq_pkg::CMD_REMOVE, pdq_pkg::CMD_PEEK: begin
          if (is_empty) begin
            out_res_nxt.status = pdq_pkg::ST_EMPTY;
          end else begin
            out_res_nxt.found_key    = cell_q[0].key;
            out_res_nxt.found_ref    = cell_q[0].cref;
            out_res_nxt.found_code   = cell_q[0].code;
            out_res_nxt.found_urgent = cell_q[0].urgent;
          end
        end
        default: out_res_nxt.status = pdq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      occ_r        <= occ_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire

/* src/pdq_checker.sv */
`default_nettype none
module pdq_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire pdq_pkg::in_t  in_req,
  input wire logic          out_strobe,
  input wire pdq_pkg::out_t out_res
);

  logic accept;
  logic quick_cmd;

  assign accept    = start && !busy;
  assign quick_cmd = (in_req.command != pdq_pkg::CMD_COUNT) &&
                     (in_req.command != pdq_pkg::CMD_SEARCH);

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while a scan is running");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && quick_cmd) |=> (out_strobe && !busy))
    else $error("single-cycle request gave no result in the next cycle");

  a_scan_enters_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !quick_cmd) |=> (busy && !out_strobe))
    else $error("count or search request did not start a scan");

  a_scan_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("scan ended without a result");

  a_full_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.status == pdq_pkg::ST_FULL)) |->
      ($past(accept) && ($past(in_req.command) == pdq_pkg::CMD_INSERT)))
    else $error("full status on a request that is not an insert");

endmodule

bind priority_deque_ticket_store_core pdq_checker u_pdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
`default_nettype wire
